@@ rtl/rfs_pkg.sv @@
// shared types, codes and helpers for the rgb565 frame statistics block
package rfs_pkg;

  localparam int unsigned PIX_W       = 16;
  localparam int unsigned CHAN_W      = 6;
  localparam int unsigned MEAN_W      = 13;
  localparam int unsigned TOTAL_W     = 15;
  localparam int unsigned ROW_IDX_W   = 20;
  localparam int unsigned OUT_TDATA_W = 56;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam logic REG_ROW_WIDTH    = 1'b0;
  localparam logic REG_FRAME_PIXELS = 1'b1;

  localparam logic [12:0] ROW_WIDTH_RST    = 13'd320;
  localparam logic [20:0] FRAME_PIXELS_RST = 21'd76800;

  typedef struct packed {
    logic       frame_end;
    logic       row_end;
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
  } pix_entry_t;

  function automatic logic [CHAN_W-1:0] pix_chan(pix_entry_t e, logic [1:0] ch);
    logic [CHAN_W-1:0] v;
    case (ch)
      CH_RED:   v = {1'b0, e.r};
      CH_GREEN: v = e.g;
      default:  v = {1'b0, e.b};
    endcase
    return v;
  endfunction

endpackage

@@ rtl/rgb565_frame_stats_seam.sv @@
// top level of the rgb565 frame statistics and seam finder
//
// channel    dir  handshake              payload
// s_axis     in   tvalid / tready        tdata[15:0] pixel
// m_axis     out  tvalid / tready        tdata[55:0] result, tlast on blue
// apb        in   psel, penable, pwrite  paddr[2:0], pwdata / prdata
//
// the intake takes one pixel a cycle while the four-entry queue has room
// the engine accumulates each pixel while idle; a row end adds three divisions
// of the row means on the shared divider plus a seam update
// a frame end adds three divisions of the frame means, then three results
// a stalled m_axis holds the engine but the intake keeps filling the queue
// reset clears all statistics at once; no clearing pass is needed
module rgb565_frame_stats_seam #(
  parameter int unsigned MAX_ROW_PIXELS   = 4096,
  parameter int unsigned MAX_FRAME_PIXELS = 1048576
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [rfs_pkg::PIX_W-1:0]       s_axis_tdata,   // pixel
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // channel[1:0], chan_min[7:2], chan_max[13:8], chan_mean[19:14],
  // seam_row[39:20], seam_delta[52:40], zero fill[55:53]
  output logic [rfs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast,   // last
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import rfs_pkg::*;

  localparam int unsigned RCW = $clog2(MAX_ROW_PIXELS + 1);
  localparam int unsigned FCW = $clog2(MAX_FRAME_PIXELS + 1);
  localparam int unsigned RSW = $clog2(MAX_ROW_PIXELS * 63 + 1);
  localparam int unsigned FSW = $clog2(MAX_FRAME_PIXELS * 63 + 1);
  localparam int unsigned RDW = $clog2(MAX_ROW_PIXELS * 6300 + 1);
  localparam int unsigned DW  = (RDW > FSW) ? RDW : FSW;
  localparam int unsigned VW  = (RCW > FCW) ? RCW : FCW;
  localparam int unsigned EW  = $bits(pix_entry_t);

  logic [12:0]       row_width_q;
  logic [20:0]       frame_pixels_q;
  logic              cfg_wr;

  pix_entry_t        push_entry, pop_entry;
  logic [EW-1:0]     fifo_dout;
  logic              push, pop, full, empty;
  logic              div_start, div_done;
  logic [DW-1:0]     div_dividend;
  logic [VW-1:0]     div_divisor;
  logic [MEAN_W-1:0] div_quot;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q    <= ROW_WIDTH_RST;
      frame_pixels_q <= FRAME_PIXELS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ROW_WIDTH:    row_width_q    <= pwdata[12:0];
        REG_FRAME_PIXELS: frame_pixels_q <= pwdata[20:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ROW_WIDTH:    prdata = 32'(row_width_q);
      REG_FRAME_PIXELS: prdata = 32'(frame_pixels_q);
      default:          prdata = '0;
    endcase
  end

  rfs_front #(
    .MAX_ROW_PIXELS  (MAX_ROW_PIXELS),
    .MAX_FRAME_PIXELS(MAX_FRAME_PIXELS),
    .RCW             (RCW),
    .FCW             (FCW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_o    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .row_width_i   (row_width_q),
    .frame_pixels_i(frame_pixels_q),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  rfs_fifo #(
    .W    (EW),
    .DEPTH(4)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .din_i  (push_entry),
    .full_o (full),
    .pop_i  (pop),
    .dout_o (fifo_dout),
    .empty_o(empty)
  );

  assign pop_entry = pix_entry_t'(fifo_dout);

  rfs_div #(
    .DW(DW),
    .VW(VW),
    .QW(MEAN_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  rfs_back #(
    .RCW(RCW),
    .FCW(FCW),
    .RSW(RSW),
    .FSW(FSW),
    .RDW(RDW),
    .DW (DW),
    .VW (VW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .entry_i       (pop_entry),
    .pop_o         (pop),
    .div_start_o   (div_start),
    .div_dividend_o(div_dividend),
    .div_divisor_o (div_divisor),
    .div_done_i    (div_done),
    .div_quot_i    (div_quot),
    .m_tvalid_o    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_o     (m_axis_tdata),
    .m_tlast_o     (m_axis_tlast)
  );

  // the mean of a frame always lies between its min and max
  a_mean_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:2] <= m_axis_tdata[19:14]) &&
                      (m_axis_tdata[19:14] <= m_axis_tdata[13:8]))
    else $error("frame mean outside min/max");

  // a mean step times 100 never exceeds 63 * 100
  a_delta_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[52:40] <= 13'd6300)
    else $error("seam delta out of range");

  // the three results of a burst follow back to back in channel order
  a_burst_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && (m_axis_tdata[1:0] == $past(m_axis_tdata[1:0]) + 2'd1))
    else $error("result burst out of order");

  // the blue result closes the burst
  a_last_blue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[1:0] == CH_BLUE)
    else $error("last flag not on blue result");

endmodule

@@ rtl/rfs_front.sv @@
// pixel intake: splits channels and marks row and frame ends
module rfs_front #(
  parameter int unsigned MAX_ROW_PIXELS   = 4096,
  parameter int unsigned MAX_FRAME_PIXELS = 1048576,
  parameter int unsigned RCW              = 13,
  parameter int unsigned FCW              = 21
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  logic [15:0]         s_tdata_i,
  input  logic [12:0]         row_width_i,
  input  logic [20:0]         frame_pixels_i,
  input  logic                full_i,
  output logic                push_o,
  output rfs_pkg::pix_entry_t entry_o
);
  import rfs_pkg::*;

  logic [RCW-1:0] row_cnt_q, row_cnt_d, row_inc, eff_row;
  logic [FCW-1:0] frame_cnt_q, frame_cnt_d, frame_inc, eff_frame;
  logic           row_end, frame_end;

  always_comb begin
    if (row_width_i == '0 || 32'(row_width_i) > 32'(MAX_ROW_PIXELS)) begin
      eff_row = RCW'(MAX_ROW_PIXELS);
    end else begin
      eff_row = RCW'(row_width_i);
    end
    if (frame_pixels_i == '0 || 32'(frame_pixels_i) > 32'(MAX_FRAME_PIXELS)) begin
      eff_frame = FCW'(MAX_FRAME_PIXELS);
    end else begin
      eff_frame = FCW'(frame_pixels_i);
    end
  end

  assign row_inc   = row_cnt_q + 1'b1;
  assign frame_inc = frame_cnt_q + 1'b1;
  assign frame_end = frame_inc >= eff_frame;
  // a short last row closes with the frame
  assign row_end   = (row_inc >= eff_row) || frame_end;

  assign s_tready_o = !full_i;
  assign push_o     = s_tvalid_i && !full_i;

  assign entry_o.frame_end = frame_end;
  assign entry_o.row_end   = row_end;
  assign entry_o.r         = s_tdata_i[15:11];
  assign entry_o.g         = s_tdata_i[10:5];
  assign entry_o.b         = s_tdata_i[4:0];

  always_comb begin
    row_cnt_d   = row_cnt_q;
    frame_cnt_d = frame_cnt_q;
    if (push_o) begin
      row_cnt_d   = row_end ? '0 : row_inc;
      frame_cnt_d = frame_end ? '0 : frame_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q   <= '0;
      frame_cnt_q <= '0;
    end else begin
      row_cnt_q   <= row_cnt_d;
      frame_cnt_q <= frame_cnt_d;
    end
  end

endmodule

@@ rtl/rfs_fifo.sv @@
// short request queue between intake and statistics engine
module rfs_fifo #(
  parameter int unsigned W     = 18,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] din_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] dout_o,
  output logic         empty_o
);
  import rfs_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [AW:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == (AW+1)'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign dout_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // depth is a power of two so the pointers wrap on their own
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= din_i;
    end
  end

endmodule

@@ rtl/rfs_div.sv @@
// restoring divider, one quotient bit per cycle, quotient known to fit QW bits
module rfs_div #(
  parameter int unsigned DW = 29,
  parameter int unsigned VW = 21,
  parameter int unsigned QW = 13
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [QW-1:0] quot_o
);
  import rfs_pkg::*;

  localparam int unsigned CW = (DW > VW + QW - 1) ? DW : VW + QW - 1;
  localparam int unsigned SW = $clog2(QW + 1);

  logic [DW-1:0] rem_q;
  logic [CW-1:0] den_q;
  logic [QW-1:0] quot_q;
  logic [SW-1:0] step_q;
  logic          busy_q, done_q;
  logic [CW-1:0] rem_ext;
  logic          fits;

  assign rem_ext = CW'(rem_q);
  assign fits    = rem_ext >= den_q;
  assign done_o  = done_q;
  assign quot_o  = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= SW'(QW);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == SW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      den_q  <= CW'(divisor_i) << (QW - 1);
      quot_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= DW'(rem_ext - den_q);
      end
      quot_q <= {quot_q[QW-2:0], fits};
      den_q  <= den_q >> 1;
    end
  end

endmodule

@@ rtl/rfs_back.sv @@
// statistics engine: accumulates, closes rows, tracks the seam, sends results
module rfs_back #(
  parameter int unsigned RCW = 13,
  parameter int unsigned FCW = 21,
  parameter int unsigned RSW = 18,
  parameter int unsigned FSW = 26,
  parameter int unsigned RDW = 25,
  parameter int unsigned DW  = 26,
  parameter int unsigned VW  = 21
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               empty_i,
  input  rfs_pkg::pix_entry_t                entry_i,
  output logic                               pop_o,
  output logic                               div_start_o,
  output logic [DW-1:0]                      div_dividend_o,
  output logic [VW-1:0]                      div_divisor_o,
  input  logic                               div_done_i,
  input  logic [rfs_pkg::MEAN_W-1:0]         div_quot_i,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  output logic [rfs_pkg::OUT_TDATA_W-1:0]    m_tdata_o,
  output logic                               m_tlast_o
);
  import rfs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROW_DIV, ST_ROW_WAIT, ST_SEAM, ST_FRM_DIV, ST_FRM_WAIT, ST_EMIT
  } state_e;

  state_e               state_q;
  logic [1:0]           ch_q;
  logic                 frame_end_q;
  logic [CHAN_W-1:0]    fmin_q [3];
  logic [CHAN_W-1:0]    fmax_q [3];
  logic [FSW-1:0]       fsum_q [3];
  logic [RSW-1:0]       rsum_q [3];
  logic [MEAN_W-1:0]    prev_mean_q [3];
  logic [MEAN_W-1:0]    mean_q [3];
  logic [MEAN_W-1:0]    best_delta_q [3];
  logic [TOTAL_W-1:0]   best_total_q;
  logic [ROW_IDX_W-1:0] best_row_q, row_idx_q;
  logic [RCW-1:0]       rcnt_q;
  logic [FCW-1:0]       fcnt_q;
  logic                 out_valid_q, out_last_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic [MEAN_W-1:0]    diff [3];
  logic [TOTAL_W-1:0]   total;
  logic [RDW-1:0]       rs_ext, row100;
  logic                 emit_go;

  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign div_start_o = (state_q == ST_ROW_DIV) || (state_q == ST_FRM_DIV);

  // row sum times 100 as shifts and adds
  assign rs_ext = RDW'(rsum_q[ch_q]);
  assign row100 = (rs_ext << 6) + (rs_ext << 5) + (rs_ext << 2);

  always_comb begin
    if (state_q == ST_FRM_DIV) begin
      div_dividend_o = DW'(fsum_q[ch_q]);
      div_divisor_o  = VW'(fcnt_q);
    end else begin
      div_dividend_o = DW'(row100);
      div_divisor_o  = VW'(rcnt_q);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = (prev_mean_q[k] > mean_q[k]) ? prev_mean_q[k] - mean_q[k]
                                             : mean_q[k] - prev_mean_q[k];
    end
    total = TOTAL_W'(diff[0]) + TOTAL_W'(diff[1]) + TOTAL_W'(diff[2]);
  end

  assign emit_go    = !out_valid_q || m_tready_i;
  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ch_q         <= CH_RED;
      frame_end_q  <= 1'b0;
      best_total_q <= '0;
      best_row_q   <= '0;
      row_idx_q    <= '0;
      rcnt_q       <= '0;
      fcnt_q       <= '0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
      out_data_q   <= '0;
      for (int k = 0; k < 3; k++) begin
        fmin_q[k]       <= '1;
        fmax_q[k]       <= '0;
        fsum_q[k]       <= '0;
        rsum_q[k]       <= '0;
        prev_mean_q[k]  <= '0;
        mean_q[k]       <= '0;
        best_delta_q[k] <= '0;
      end
    end else begin
      // while emitting, the emit arm decides the output register
      if (out_valid_q && m_tready_i && state_q != ST_EMIT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            for (int k = 0; k < 3; k++) begin
              if (pix_chan(entry_i, 2'(k)) < fmin_q[k]) begin
                fmin_q[k] <= pix_chan(entry_i, 2'(k));
              end
              if (pix_chan(entry_i, 2'(k)) > fmax_q[k]) begin
                fmax_q[k] <= pix_chan(entry_i, 2'(k));
              end
              fsum_q[k] <= fsum_q[k] + FSW'(pix_chan(entry_i, 2'(k)));
              rsum_q[k] <= rsum_q[k] + RSW'(pix_chan(entry_i, 2'(k)));
            end
            rcnt_q      <= rcnt_q + 1'b1;
            fcnt_q      <= fcnt_q + 1'b1;
            frame_end_q <= entry_i.frame_end;
            if (entry_i.row_end) begin
              ch_q    <= CH_RED;
              state_q <= ST_ROW_DIV;
            end
          end
        end
        ST_ROW_DIV: begin
          state_q <= ST_ROW_WAIT;
        end
        ST_ROW_WAIT: begin
          if (div_done_i) begin
            mean_q[ch_q] <= div_quot_i;
            if (ch_q == CH_BLUE) begin
              state_q <= ST_SEAM;
            end else begin
              ch_q    <= ch_q + 1'b1;
              state_q <= ST_ROW_DIV;
            end
          end
        end
        ST_SEAM: begin
          // first row has no predecessor; ties keep the earlier row
          if (row_idx_q != '0 && total > best_total_q) begin
            best_total_q <= total;
            best_row_q   <= row_idx_q;
            for (int k = 0; k < 3; k++) begin
              best_delta_q[k] <= diff[k];
            end
          end
          for (int k = 0; k < 3; k++) begin
            prev_mean_q[k] <= mean_q[k];
            rsum_q[k]      <= '0;
          end
          rcnt_q    <= '0;
          row_idx_q <= row_idx_q + 1'b1;
          ch_q      <= CH_RED;
          state_q   <= frame_end_q ? ST_FRM_DIV : ST_IDLE;
        end
        ST_FRM_DIV: begin
          state_q <= ST_FRM_WAIT;
        end
        ST_FRM_WAIT: begin
          if (div_done_i) begin
            mean_q[ch_q] <= div_quot_i;
            if (ch_q == CH_BLUE) begin
              ch_q    <= CH_RED;
              state_q <= ST_EMIT;
            end else begin
              ch_q    <= ch_q + 1'b1;
              state_q <= ST_FRM_DIV;
            end
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_valid_q <= 1'b1;
            out_last_q  <= ch_q == CH_BLUE;
            out_data_q  <= {3'b000, best_delta_q[ch_q], best_row_q,
                            mean_q[ch_q][CHAN_W-1:0], fmax_q[ch_q], fmin_q[ch_q], ch_q};
            if (ch_q == CH_BLUE) begin
              // frame done, back to reset values
              for (int k = 0; k < 3; k++) begin
                fmin_q[k]       <= '1;
                fmax_q[k]       <= '0;
                fsum_q[k]       <= '0;
                prev_mean_q[k]  <= '0;
                best_delta_q[k] <= '0;
              end
              fcnt_q       <= '0;
              row_idx_q    <= '0;
              best_total_q <= '0;
              best_row_q   <= '0;
              frame_end_q  <= 1'b0;
              ch_q         <= CH_RED;
              state_q      <= ST_IDLE;
            end else begin
              ch_q <= ch_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/frame_stats_checker.sv @@
// checker for the rgb565 frame statistics block: own model of the statistics, result comparison
`timescale 1ns / 100ps
module frame_stats_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_valid_i,
  input  logic                            s_ready_i,
  input  logic [rfs_pkg::PIX_W-1:0]       s_data_i,
  input  logic                            m_valid_i,
  input  logic                            m_ready_i,
  input  logic [rfs_pkg::OUT_TDATA_W-1:0] m_data_i,
  input  logic                            m_last_i,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic                            pready_i,
  input  logic [2:0]                      paddr_i,
  input  logic [31:0]                     pwdata_i,
  input  logic [31:0]                     prdata_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);
  import rfs_pkg::*;

  localparam int unsigned MAX_ROW_PIXELS   = 4096;
  localparam int unsigned MAX_FRAME_PIXELS = 1048576;

  typedef struct packed {
    logic [1:0]           channel;
    logic [CHAN_W-1:0]    lo;
    logic [CHAN_W-1:0]    hi;
    logic [CHAN_W-1:0]    mean;
    logic [ROW_IDX_W-1:0] seam_row;
    logic [MEAN_W-1:0]    seam_delta;
    logic                 last;
  } chan_stats_t;

  chan_stats_t chan_stats_q[$];
  chan_stats_t want;

  logic [12:0]          row_width_q;
  logic [20:0]          frame_pixels_q;
  logic [CHAN_W-1:0]    lo_q[3];
  logic [CHAN_W-1:0]    hi_q[3];
  logic [25:0]          frame_sum_q[3];
  logic [20:0]          frame_cnt_q;
  logic [17:0]          row_sum_q[3];
  logic [12:0]          row_cnt_q;
  logic [ROW_IDX_W-1:0] row_idx_q;
  logic [MEAN_W-1:0]    prev_mean_q[3];
  logic [TOTAL_W-1:0]   best_total_q;
  logic [ROW_IDX_W-1:0] best_row_q;
  logic [MEAN_W-1:0]    best_delta_q[3];
  int unsigned          fails;

  task automatic clear_frame();
    for (int k = 0; k < 3; k++) begin
      lo_q[k]         = '1;
      hi_q[k]         = '0;
      frame_sum_q[k]  = '0;
      row_sum_q[k]    = '0;
      prev_mean_q[k]  = '0;
      best_delta_q[k] = '0;
    end
    frame_cnt_q  = '0;
    row_cnt_q    = '0;
    row_idx_q    = '0;
    best_total_q = '0;
    best_row_q   = '0;
  endtask

  task automatic compare_field(input string what, input int unsigned exp_v,
                               input int unsigned got_v);
    if (exp_v != got_v) begin
      fails++;
      $display("%0t: %s expected %0d, got %0d", $time, what, exp_v, got_v);
    end
  endtask

  // update the frame and row statistics with one pixel, queue a burst on frame end
  task automatic take_pixel(input logic [PIX_W-1:0] px);
    logic [CHAN_W-1:0] ch[3];
    int unsigned       mean[3];
    int unsigned       step[3];
    int unsigned       total;
    int unsigned       eff_row;
    int unsigned       eff_frame;
    logic              frame_end;
    chan_stats_t       r;
    ch[0] = {1'b0, px[15:11]};
    ch[1] = px[10:5];
    ch[2] = {1'b0, px[4:0]};
    for (int k = 0; k < 3; k++) begin
      if (ch[k] < lo_q[k]) lo_q[k] = ch[k];
      if (ch[k] > hi_q[k]) hi_q[k] = ch[k];
      frame_sum_q[k] = frame_sum_q[k] + ch[k];
      row_sum_q[k]   = row_sum_q[k] + ch[k];
    end
    frame_cnt_q = frame_cnt_q + 1'b1;
    row_cnt_q   = row_cnt_q + 1'b1;
    eff_row   = (row_width_q == 0 || row_width_q > MAX_ROW_PIXELS) ?
                MAX_ROW_PIXELS : row_width_q;
    eff_frame = (frame_pixels_q == 0 || frame_pixels_q > MAX_FRAME_PIXELS) ?
                MAX_FRAME_PIXELS : frame_pixels_q;
    frame_end = (frame_cnt_q >= eff_frame);
    if (row_cnt_q >= eff_row || frame_end) begin
      total = 0;
      for (int k = 0; k < 3; k++) begin
        mean[k] = (int'(row_sum_q[k]) * 100) / int'(row_cnt_q);
        step[k] = (prev_mean_q[k] > mean[k]) ? prev_mean_q[k] - mean[k]
                                             : mean[k] - prev_mean_q[k];
        total   = total + step[k];
      end
      // first row has nothing to step from; ties keep the earlier row
      if (row_idx_q != 0 && total > best_total_q) begin
        best_total_q = total[TOTAL_W-1:0];
        best_row_q   = row_idx_q;
        for (int k = 0; k < 3; k++) best_delta_q[k] = step[k][MEAN_W-1:0];
      end
      for (int k = 0; k < 3; k++) begin
        prev_mean_q[k] = mean[k][MEAN_W-1:0];
        row_sum_q[k]   = '0;
      end
      row_cnt_q = '0;
      row_idx_q = row_idx_q + 1'b1;
    end
    if (frame_end) begin
      for (int k = 0; k < 3; k++) begin
        case (k)
          0:       r.channel = CH_RED;
          1:       r.channel = CH_GREEN;
          default: r.channel = CH_BLUE;
        endcase
        r.lo         = lo_q[k];
        r.hi         = hi_q[k];
        r.mean       = CHAN_W'(int'(frame_sum_q[k]) / int'(frame_cnt_q));
        r.seam_row   = best_row_q;
        r.seam_delta = best_delta_q[k];
        r.last       = (r.channel == CH_BLUE);
        chan_stats_q.push_back(r);
      end
      clear_frame();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q    = ROW_WIDTH_RST;
      frame_pixels_q = FRAME_PIXELS_RST;
      clear_frame();
      chan_stats_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          if (paddr_i[2] == REG_ROW_WIDTH) row_width_q = pwdata_i[12:0];
          else                             frame_pixels_q = pwdata_i[20:0];
        end else if (paddr_i[2] == REG_ROW_WIDTH) begin
          compare_field("row_width readback", row_width_q, prdata_i);
        end else begin
          compare_field("frame_pixels readback", frame_pixels_q, prdata_i);
        end
      end
      if (s_valid_i && s_ready_i) take_pixel(s_data_i);
      if (m_valid_i && m_ready_i) begin
        if (chan_stats_q.size() == 0) begin
          fails++;
          $display("%0t: expected no result, got tdata %h tlast %b",
                   $time, m_data_i, m_last_i);
        end else begin
          want = chan_stats_q.pop_front();
          compare_field("channel",    want.channel,    m_data_i[1:0]);
          compare_field("chan_min",   want.lo,         m_data_i[7:2]);
          compare_field("chan_max",   want.hi,         m_data_i[13:8]);
          compare_field("chan_mean",  want.mean,       m_data_i[19:14]);
          compare_field("seam_row",   want.seam_row,   m_data_i[39:20]);
          compare_field("seam_delta", want.seam_delta, m_data_i[52:40]);
          compare_field("zero fill",  0,               m_data_i[55:53]);
          compare_field("last",       want.last,       m_last_i);
        end
      end
      fail_count_o <= fails;
      pending_o    <= chan_stats_q.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
// testbench top: clock, reset, pixel and register stimulus, verdict for the frame statistics block
`timescale 1ns / 100ps
module tb_top;
  import rfs_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 600;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [PIX_W-1:0]       s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [2:0]             paddr         = '0;
  logic [31:0]            pwdata        = '0;
  logic [31:0]            prdata;
  logic                   pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycles         = 0;

  rgb565_frame_stats_seam dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  frame_stats_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .m_last_i     (m_axis_tlast),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("rgb565_frame_stats_seam: mismatch");
      $finish;
    end
  end

  // setup then access cycle, then psel low before the next request so that requests never abut
  task automatic apb_access(input logic wr, input logic idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] row_width, input logic [31:0] frame_pixels);
    apb_access(1'b1, REG_ROW_WIDTH, row_width);
    apb_access(1'b1, REG_FRAME_PIXELS, frame_pixels);
    apb_access(1'b0, REG_ROW_WIDTH, '0);
    apb_access(1'b0, REG_FRAME_PIXELS, '0);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] px);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  // hold the pixel stream until every queued result is out, then idle a while
  task automatic wait_results(input int unsigned extra);
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(input logic [PIX_W-1:0] prev);
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return prev;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // mostly whole frames of random content, now and then a frame cut short
  task automatic random_run(input int unsigned target);
    int unsigned      sent;
    int unsigned      row_width;
    int unsigned      frame_pixels;
    int unsigned      n;
    logic [PIX_W-1:0] px;
    sent = 0;
    px   = '0;
    while (sent < target) begin
      case ($urandom_range(9))
        0:       row_width = 4096;
        1:       row_width = 0;
        2:       row_width = $urandom_range(7, 8191);
        default: row_width = $urandom_range(1, 6);
      endcase
      frame_pixels = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      n = $urandom_range(1, 3) * frame_pixels;
      if ($urandom_range(3) == 0) n = n + $urandom_range(1, frame_pixels);
      set_config(row_width, frame_pixels);
      for (int i = 0; i < n; i++) begin
        px = pick_pixel(px);
        send_pixel(px);
        sent++;
        if ((i + 1) % frame_pixels == 0 && $urandom_range(7) == 0) wait_results(0);
      end
      wait_results(SETTLE_CYCLES);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset values
    apb_access(1'b0, REG_ROW_WIDTH, '0);
    apb_access(1'b0, REG_FRAME_PIXELS, '0);

    // single-pixel frames at the value extremes
    set_config(1, 1);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    wait_results(SETTLE_CYCLES);

    // one channel at a time, short last row
    set_config(2, 5);
    send_pixel(16'hF800);
    send_pixel(16'h07E0);
    send_pixel(16'h001F);
    send_pixel(16'hFFFF);
    send_pixel(16'h8410);
    wait_results(SETTLE_CYCLES);

    // equal steps on every row, the earliest must win
    set_config(1, 4);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    wait_results(SETTLE_CYCLES);

    // flat frame, no step anywhere
    set_config(1, 3);
    repeat (3) send_pixel(16'h5555);
    wait_results(SETTLE_CYCLES);

    // registers changed mid-row and mid-frame, stats must carry over
    set_config(4, 8);
    send_pixel(16'h1234);
    send_pixel(16'hABCD);
    send_pixel(16'h7BEF);
    wait_results(SETTLE_CYCLES);
    set_config(2, 0);
    send_pixel(16'h0841);
    send_pixel(16'hF7DE);
    wait_results(SETTLE_CYCLES);
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(16'hC618);
    wait_results(SETTLE_CYCLES);
    set_config(4096, 1048576);
    send_pixel(16'h39E7);
    wait_results(SETTLE_CYCLES);
    set_config(3, 3);
    send_pixel(16'hE71C);
    wait_results(SETTLE_CYCLES);

    send_gap_pct   = 6;
    recv_stall_pct = 70;
    random_run(62);
    send_gap_pct   = 70;
    recv_stall_pct = 6;
    random_run(62);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    random_run(62);

    wait_results(SETTLE_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("rgb565_frame_stats_seam: match");
    end else begin
      $display("rgb565_frame_stats_seam: mismatch");
    end
    $finish;
  end

endmodule
